[design/mrrb_pkg.sv]
// ----------------------------------------------------------------------------
// mrrb_pkg
// Shared constants, command codes and types of the multi-reader ring buffer.
// ----------------------------------------------------------------------------
package mrrb_pkg;

  localparam int DEPTH       = 1024;
  localparam int READERS     = 4;
  localparam int ADDR_W      = 10;
  localparam int LEN_W       = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [7:0]       FILL_BYTE        = 8'd48;
  localparam logic [LEN_W-1:0] RING_LEN_RESET   = 11'd1024;
  localparam logic [2:0]       ACTIVE_RESET     = 3'd1;

  localparam logic [1:0] CMD_WRITE_BYTE   = 2'd0;
  localparam logic [1:0] CMD_COMMIT_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ_BYTE    = 2'd2;
  localparam logic [1:0] CMD_COMMIT_READ  = 2'd3;

  localparam logic CFG_RING_LENGTH    = 1'b0;
  localparam logic CFG_ACTIVE_READERS = 1'b1;

  // One classified command on its way from the front to the back
  typedef struct packed {
    logic                              status;
    logic                              do_write;
    logic                              do_read;
    logic [ADDR_W-1:0]                 addr;
    logic [7:0]                        data;
    logic [READERS-1:0][ADDR_W-1:0]    space;
    logic [ADDR_W-1:0]                 avail;
    logic [LEN_W-1:0]                  contig;
    logic [ADDR_W-1:0]                 start;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[design/mrrb_ram.sv]
// ----------------------------------------------------------------------------
// mrrb_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mrrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[design/mrrb_fifo.sv]
// ----------------------------------------------------------------------------
// mrrb_fifo
// Short queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module mrrb_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mrrb_pkg::entry_t    push_entry,
  input  logic                pop,
  output mrrb_pkg::entry_t    pop_entry,
  output mrrb_pkg::fifo_stat_t stat
);

  mrrb_pkg::entry_t                  entries [mrrb_pkg::QUEUE_DEPTH];
  logic [mrrb_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mrrb_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mrrb_pkg::QCNT_W-1:0]       count;

  assign pop_entry  = entries[rd_ptr];
  assign stat.full  = (count == mrrb_pkg::QCNT_W'(mrrb_pkg::QUEUE_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/mrrb_front.sv]
// ----------------------------------------------------------------------------
// mrrb_front
// Accepts commands, checks arguments, moves head and tails, and works out
// the reported figures from the updated pointers in a second stage.
// ----------------------------------------------------------------------------
module mrrb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [10:0]          cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 clr_busy,
  input  mrrb_pkg::fifo_stat_t fifo_stat,
  output logic                 push,
  output mrrb_pkg::entry_t     push_entry
);

  localparam int AW = mrrb_pkg::ADDR_W;
  localparam int LW = mrrb_pkg::LEN_W;

  logic [LW-1:0] ring_len;
  logic [2:0]    active;
  logic [AW-1:0] head;
  logic [AW-1:0] tails [mrrb_pkg::READERS];

  logic          s2_valid;
  logic          s2_status;
  logic [1:0]    s2_cmd;
  logic [AW-1:0] s2_addr;
  logic [7:0]    s2_data;
  logic [1:0]    s2_rid;
  logic [LW-1:0] s2_len;

  // Stage 1: decode and pointer update
  logic [1:0]    cmd;
  logic [1:0]    rid;
  logic [AW-1:0] off;
  logic [LW-1:0] len;
  logic [7:0]    dbyte;
  logic          rid_ok;
  logic          off_bad;
  logic          len_bad;
  logic          bad;
  logic [AW-1:0] base;
  logic [LW-1:0] step;
  logic [LW:0]   sum;
  logic [LW:0]   wrapped;
  logic [AW-1:0] wrap_pos;
  logic          accept;
  logic [LW-1:0] rl_clamped;
  logic [2:0]    act_clamped;

  assign cmd   = s_tuser;
  assign rid   = s_tdata[1:0];
  assign off   = s_tdata[11:2];
  assign len   = s_tdata[22:12];
  assign dbyte = s_tdata[30:23];

  assign rid_ok  = (int'(rid) < mrrb_pkg::READERS);
  assign off_bad = ({1'b0, off} >= ring_len);
  assign len_bad = (len > ring_len);

  always_comb begin
    case (cmd)
      mrrb_pkg::CMD_WRITE_BYTE:   bad = off_bad;
      mrrb_pkg::CMD_COMMIT_WRITE: bad = len_bad;
      mrrb_pkg::CMD_READ_BYTE:    bad = !rid_ok || off_bad;
      mrrb_pkg::CMD_COMMIT_READ:  bad = !rid_ok || len_bad;
      default:                    bad = 1'b1;
    endcase
  end

  assign base = (cmd inside {mrrb_pkg::CMD_WRITE_BYTE, mrrb_pkg::CMD_COMMIT_WRITE}) ?
                head : tails[rid];
  assign step = (cmd inside {mrrb_pkg::CMD_WRITE_BYTE, mrrb_pkg::CMD_READ_BYTE}) ?
                {1'b0, off} : len;
  assign sum      = (LW+1)'(base) + (LW+1)'(step);
  assign wrapped  = (sum >= (LW+1)'(ring_len)) ? (sum - (LW+1)'(ring_len)) : sum;
  assign wrap_pos = wrapped[AW-1:0];

  assign s_tready = !clr_busy && (!s2_valid || !fifo_stat.full);
  assign accept   = s_tvalid && s_tready;
  assign push     = s2_valid && !fifo_stat.full;

  assign rl_clamped = (cfg_data < 11'd2) ? 11'd2 :
                      (cfg_data > LW'(mrrb_pkg::DEPTH)) ? LW'(mrrb_pkg::DEPTH) : cfg_data;
  assign act_clamped = (cfg_data[2:0] > 3'(mrrb_pkg::READERS)) ?
                       3'(mrrb_pkg::READERS) : cfg_data[2:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_len <= mrrb_pkg::RING_LEN_RESET;
      active   <= mrrb_pkg::ACTIVE_RESET;
      head     <= '0;
      for (int i = 0; i < mrrb_pkg::READERS; i++) begin
        tails[i] <= '0;
      end
      s2_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mrrb_pkg::CFG_RING_LENGTH: begin
            // a new length restarts all pointers
            ring_len <= rl_clamped;
            head     <= '0;
            for (int i = 0; i < mrrb_pkg::READERS; i++) begin
              tails[i] <= '0;
            end
          end
          mrrb_pkg::CFG_ACTIVE_READERS: active <= act_clamped;
          default: ;
        endcase
      end
      if (accept && !bad) begin
        if (cmd == mrrb_pkg::CMD_COMMIT_WRITE) begin
          head <= wrap_pos;
        end else if (cmd == mrrb_pkg::CMD_COMMIT_READ) begin
          tails[rid] <= wrap_pos;
        end
      end
      if (accept) begin
        s2_valid <= 1'b1;
      end else if (push) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_status <= bad;
      s2_cmd    <= cmd;
      s2_addr   <= wrap_pos;
      s2_data   <= dbyte;
      s2_rid    <= rid;
      s2_len    <= len;
    end
  end

  // Stage 2: figures from the pointers as this command left them
  logic [LW-1:0] lm1;
  logic [AW-1:0] sel_t;
  logic          s2_rid_ok;
  logic [LW-1:0] tail_gap;

  assign lm1       = ring_len - 1'b1;
  assign s2_rid_ok = (int'(s2_rid) < mrrb_pkg::READERS);
  assign sel_t     = tails[s2_rid];
  assign tail_gap  = ring_len - LW'(sel_t);

  always_comb begin
    logic [LW-1:0] raw;
    logic [LW-1:0] sp;
    logic [LW-1:0] av;
    push_entry.status   = s2_status;
    push_entry.do_write = (s2_cmd == mrrb_pkg::CMD_WRITE_BYTE) && !s2_status;
    push_entry.do_read  = (s2_cmd == mrrb_pkg::CMD_READ_BYTE) && !s2_status;
    push_entry.addr     = s2_addr;
    push_entry.data     = s2_data;
    for (int i = 0; i < mrrb_pkg::READERS; i++) begin
      raw = LW'(tails[i]) - LW'(head) + ((tails[i] < head) ? ring_len : '0);
      sp  = (raw == '0) ? lm1 : (raw - 1'b1);
      push_entry.space[i] = (i < int'(active)) ? sp[AW-1:0] : lm1[AW-1:0];
    end
    if (sel_t < head) begin
      av = LW'(head) - LW'(sel_t);
    end else if (sel_t > head) begin
      av = tail_gap + LW'(head);
    end else begin
      av = '0;
    end
    if (s2_rid_ok) begin
      push_entry.avail  = av[AW-1:0];
      push_entry.contig = ((sel_t < head) || (tail_gap >= s2_len)) ? s2_len : tail_gap;
      push_entry.start  = sel_t;
    end else begin
      push_entry.avail  = '0;
      push_entry.contig = '0;
      push_entry.start  = '0;
    end
  end

endmodule

[design/mrrb_back.sv]
// ----------------------------------------------------------------------------
// mrrb_back
// Clears the ring after reset, then carries out byte writes and reads in
// queue order and forms the result transactions.
// ----------------------------------------------------------------------------
module mrrb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mrrb_pkg::fifo_stat_t fifo_stat,
  input  mrrb_pkg::entry_t     pop_entry,
  output logic                 pop,
  output logic                 clr_busy,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,
  output logic [0:0]           m_tuser
);

  localparam int AW = mrrb_pkg::ADDR_W;

  logic             clr_busy_r;
  logic [AW-1:0]    clr_addr;
  logic             pend_valid;
  mrrb_pkg::entry_t pend;
  logic             pend_advance;

  logic             out_valid;
  logic             out_status;
  logic [7:0]       out_rval;
  logic [AW-1:0]    out_space;
  logic [AW-1:0]    out_avail;
  logic [10:0]      out_contig;
  logic [AW-1:0]    out_start;

  logic             ram_we;
  logic             ram_re;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic [AW-1:0]    best;

  assign clr_busy     = clr_busy_r;
  assign pend_advance = pend_valid && (!out_valid || m_tready);
  assign pop          = !fifo_stat.empty && !clr_busy_r && (!pend_valid || pend_advance);

  assign ram_we    = clr_busy_r || (pop && pop_entry.do_write);
  assign ram_re    = pop && pop_entry.do_read;
  assign ram_addr  = clr_busy_r ? clr_addr : pop_entry.addr;
  assign ram_wdata = clr_busy_r ? mrrb_pkg::FILL_BYTE : pop_entry.data;

  mrrb_ram #(
    .WIDTH (8),
    .DEPTH (mrrb_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // slowest reader sets the writer space
  always_comb begin
    best = pend.space[0];
    for (int i = 1; i < mrrb_pkg::READERS; i++) begin
      if (pend.space[i] < best) begin
        best = pend.space[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy_r <= 1'b1;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(mrrb_pkg::DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (pop) begin
        pend_valid <= 1'b1;
      end else if (pend_advance) begin
        pend_valid <= 1'b0;
      end
      if (pend_advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend <= pop_entry;
    end
    if (pend_advance) begin
      out_status <= pend.status;
      out_rval   <= pend.do_read ? ram_rdata : 8'd0;
      out_space  <= best;
      out_avail  <= pend.avail;
      out_contig <= pend.contig;
      out_start  <= pend.start;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_start, out_contig, out_avail, out_space, out_rval};
  assign m_tuser  = out_status;

endmodule

[design/multi_reader_ring_buffer.sv]
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer
// Byte ring with one writer head and several reader tails, driven by a
// command stream; each command returns one status and figures transaction.
// ----------------------------------------------------------------------------
// The block takes one command per cycle while s_tready is high and returns
// one result per command, in order: a decode stage moves the pointers, a
// figures stage derives space and availability from them, a four-entry
// queue decouples this from the back, and the back performs the single
// byte access on a one-port 1024 x 8 RAM and registers the result. After
// reset the back writes the fill byte to all 1024 RAM entries, one per
// cycle, and s_tready stays low until it is done; configuration writes
// are taken during that time. Write configuration only while no command is
// in flight; writing ring_length puts the head and all tails back to zero.
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // reader_id[1:0], offset[11:2], length[22:12],
                                 // data_byte[30:23]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // read_value[7:0], writer_space[17:8],
                                 // reader_available[27:18],
                                 // contiguous_length[38:28], read_start[48:39]
  output logic [0:0]  m_tuser    // status[0]
);

  mrrb_pkg::fifo_stat_t fifo_stat;
  mrrb_pkg::entry_t     push_entry;
  mrrb_pkg::entry_t     pop_entry;
  logic                 push;
  logic                 pop;
  logic                 clr_busy;

  mrrb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .clr_busy   (clr_busy),
    .fifo_stat  (fifo_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  mrrb_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .stat       (fifo_stat)
  );

  mrrb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_stat (fifo_stat),
    .pop_entry (pop_entry),
    .pop       (pop),
    .clr_busy  (clr_busy),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // no command enters while the ring is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !s_tready)
    else $error("command accepted during ring clear");

  // the clearing pass starts right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> clr_busy)
    else $error("ring clear did not start after reset");

  // a rejected command never returns a byte
  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[7:0] == 8'd0))
    else $error("read value on a rejected command");

  // a full queue that is not popped does not become empty
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (fifo_stat.full && !pop) |=> !(fifo_stat.empty))
    else $error("queue lost entries while full");

endmodule

[dv/ring_result_checker.sv]
// ----------------------------------------------------------------------------
// ring_result_checker
// Watches the config port and both streams of the multi-reader ring buffer,
// predicts the status and figures of every accepted command and compares
// each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module ring_result_checker
  import mrrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // reader_id[1:0], offset[11:2], length[22:12],
                                 // data_byte[30:23]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [55:0] m_tdata,   // read_value[7:0], writer_space[17:8],
                                 // reader_available[27:18],
                                 // contiguous_length[38:28], read_start[48:39]
  input  logic [0:0]  m_tuser,   // status[0]
  output int unsigned error_count,
  output int unsigned pending
);

  typedef struct packed {
    logic              status;
    logic [7:0]        read_value;
    logic [ADDR_W-1:0] writer_space;
    logic [ADDR_W-1:0] reader_available;
    logic [LEN_W-1:0]  contiguous_length;
    logic [ADDR_W-1:0] read_start;
  } ring_figures_t;

  logic [7:0]    ring_bytes [DEPTH];
  int unsigned   head_pos;
  int unsigned   tail_pos [READERS];
  int unsigned   ring_len;
  int unsigned   active_cnt;
  ring_figures_t awaited_figures [$];

  function automatic int unsigned wrap_sum(int unsigned a, int unsigned b);
    int unsigned s;
    s = a + b;
    if (s >= ring_len) s = s - ring_len;
    return s;
  endfunction

  // Free slots before the slowest active reader, one slot kept as guard
  function automatic int unsigned slowest_space();
    int unsigned best, n, raw, sp;
    best = ring_len - 1;
    n = (active_cnt > READERS) ? READERS : active_cnt;
    for (int i = 0; i < n; i++) begin
      raw = (tail_pos[i] >= head_pos) ? tail_pos[i] - head_pos
                                      : tail_pos[i] + ring_len - head_pos;
      sp = (raw == 0) ? ring_len - 1 : raw - 1;
      if (sp < best) best = sp;
    end
    return best;
  endfunction

  task automatic clear_ring();
    for (int i = 0; i < DEPTH; i++) ring_bytes[i] = FILL_BYTE;
    head_pos = 0;
    for (int i = 0; i < READERS; i++) tail_pos[i] = 0;
    ring_len = (RING_LEN_RESET > DEPTH) ? DEPTH : RING_LEN_RESET;
    active_cnt = ACTIVE_RESET;
  endtask

  task automatic apply_setting(logic index, logic [10:0] value);
    int unsigned v;
    if (index == CFG_RING_LENGTH) begin
      v = value;
      if (v < 2) v = 2;
      if (v > DEPTH) v = DEPTH;
      ring_len = v;
      // new length puts every pointer back at zero, bytes stay
      head_pos = 0;
      for (int i = 0; i < READERS; i++) tail_pos[i] = 0;
    end else begin
      v = value[2:0];
      active_cnt = (v > READERS) ? READERS : v;
    end
  endtask

  function automatic ring_figures_t apply_ring_command(logic [1:0] cmd, logic [31:0] word);
    ring_figures_t res;
    int unsigned   rid, off, len, t, avail, contig;
    logic [7:0]    data_in;
    rid     = word[1:0];
    off     = word[11:2];
    len     = word[22:12];
    data_in = word[30:23];
    res     = '0;
    avail   = 0;
    contig  = 0;
    case (cmd)
      CMD_WRITE_BYTE: begin
        if (off >= ring_len) res.status = 1'b1;
        else ring_bytes[wrap_sum(head_pos, off)] = data_in;
      end
      CMD_COMMIT_WRITE: begin
        if (len > ring_len) res.status = 1'b1;
        else head_pos = wrap_sum(head_pos, len);
      end
      CMD_READ_BYTE: begin
        if (rid >= READERS || off >= ring_len) res.status = 1'b1;
        else res.read_value = ring_bytes[wrap_sum(tail_pos[rid], off)];
      end
      default: begin
        if (rid >= READERS || len > ring_len) res.status = 1'b1;
        else tail_pos[rid] = wrap_sum(tail_pos[rid], len);
      end
    endcase
    if (rid < READERS) begin
      t = tail_pos[rid];
      if (t < head_pos) avail = head_pos - t;
      else if (t > head_pos) avail = ring_len - t + head_pos;
      if (t < head_pos || ring_len - t >= len) contig = len;
      else contig = ring_len - t;
      res.reader_available  = avail;
      res.contiguous_length = contig;
      res.read_start        = t;
    end
    res.writer_space = slowest_space();
    return res;
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    ring_figures_t got, want;
    if (rst) begin
      clear_ring();
      awaited_figures.delete();
    end else begin
      // retire before predicting: a result never belongs to a command of the same edge
      if (m_tvalid && m_tready) begin
        got.status            = m_tuser[0];
        got.read_value        = m_tdata[7:0];
        got.writer_space      = m_tdata[17:8];
        got.reader_available  = m_tdata[27:18];
        got.contiguous_length = m_tdata[38:28];
        got.read_start        = m_tdata[48:39];
        if (awaited_figures.size() == 0) begin
          $display("%0t: result with nothing expected, got status %0d space %0d",
                   $time, got.status, got.writer_space);
          error_count++;
        end else begin
          want = awaited_figures.pop_front();
          compare_field("status", want.status, got.status);
          compare_field("read_value", want.read_value, got.read_value);
          compare_field("writer_space", want.writer_space, got.writer_space);
          compare_field("reader_available", want.reader_available, got.reader_available);
          compare_field("contiguous_length", want.contiguous_length,
                        got.contiguous_length);
          compare_field("read_start", want.read_start, got.read_start);
        end
      end
      if (cfg_we) apply_setting(cfg_index, cfg_data);
      if (s_tvalid && s_tready) awaited_figures.push_back(apply_ring_command(s_tuser, s_tdata));
    end
    pending = awaited_figures.size();
  end

endmodule

[dv/tb_multi_reader_ring_buffer.sv]
// ----------------------------------------------------------------------------
// tb_multi_reader_ring_buffer
// Drives commands and ring settings into the multi-reader ring buffer:
// a directed set of edge cases, then random byte writes, reads and commits
// in write and read bursts plus noise, over several ring lengths and reader
// counts, with sender gaps, receiver stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_multi_reader_ring_buffer;
  import mrrb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE      = 10;

  typedef enum {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pacing_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [10:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;
  logic [0:0]  m_tuser;

  int unsigned error_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned sent = 0;
  int unsigned cmd_count [4] = '{0, 0, 0, 0};
  int unsigned ring_cur = 1024;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;

  multi_reader_ring_buffer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  ring_result_checker u_figures_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .error_count(error_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Called and left at a falling edge; tvalid stays up for the next command
  task automatic push_cmd(logic [1:0] cmd, logic [1:0] rid, logic [9:0] off,
                          logic [10:0] len, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, data, len, off, rid};
    do @(posedge clk); while (!s_tready);
    sent++;
    cmd_count[cmd]++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic index, logic [10:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (index == CFG_RING_LENGTH)
      ring_cur = (value < 2) ? 2 : (value > DEPTH) ? DEPTH : value;
  endtask

  task automatic random_step();
    int unsigned pick, k, rid, top_off, len_pick, off, len;
    top_off = ring_cur - 1;
    pick    = $urandom_range(99);
    rid     = $urandom_range(3);
    if (pick < 8) begin
      // noise: any field value, out of range ones included
      push_cmd($urandom_range(3), rid, $urandom_range(1023), $urandom_range(2047),
               $urandom_range(255));
    end else if (pick < 22) begin
      // fill a run of bytes ahead of the head, then publish it
      k = $urandom_range(1, (ring_cur < 6) ? ring_cur : 6);
      for (int j = 0; j < k; j++)
        push_cmd(CMD_WRITE_BYTE, rid, j % ring_cur, $urandom_range(15), $urandom_range(255));
      push_cmd(CMD_COMMIT_WRITE, rid, 0, k, 0);
    end else if (pick < 36) begin
      // read a run from one reader, then release it
      k = $urandom_range(1, (ring_cur < 6) ? ring_cur : 6);
      for (int j = 0; j < k; j++)
        push_cmd(CMD_READ_BYTE, rid, j % ring_cur, $urandom_range(15), 0);
      push_cmd(CMD_COMMIT_READ, rid, 0, k, 0);
    end else begin
      off = $urandom_range(1) ? $urandom_range((top_off < 15) ? top_off : 15)
                              : $urandom_range(top_off);
      len_pick = $urandom_range(9);
      if (len_pick < 6) len = $urandom_range((ring_cur < 8) ? ring_cur : 8);
      else if (len_pick < 9) len = $urandom_range(ring_cur);
      else len = ring_cur + $urandom_range(1);
      push_cmd($urandom_range(3), rid, off, len, $urandom_range(255));
    end
  endtask

  // Leaves tvalid up; the next wait_idle drops it
  task automatic run_phase(int unsigned ring_v, int unsigned act_v, pacing_t pace,
                           int unsigned count, bit hold, bit pause);
    int unsigned target, pause_at;
    bit          paused;
    wait_idle();
    write_reg(CFG_RING_LENGTH, ring_v);
    write_reg(CFG_ACTIVE_READERS, act_v);
    // pacing changes at a rising edge so the result side picks it up cleanly
    @(posedge clk);
    send_idle_pct  = (pace == PACE_SEND) ? 86 : (pace == PACE_BOTH) ? 29 : 0;
    recv_stall_pct = (pace == PACE_RECV) ? 86 : (pace == PACE_BOTH) ? 29 : 0;
    if (hold) hold_req = 1'b1;
    @(negedge clk);
    target   = sent + count;
    pause_at = sent + count / 2;
    paused   = 1'b0;
    while (sent < target) begin
      random_step();
      if (pause && !paused && sent >= pause_at) begin
        wait_idle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = CFG_RING_LENGTH;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = CMD_WRITE_BYTE;
    m_tready  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings: full 1024 ring, one reader
    push_cmd(CMD_READ_BYTE,    0, 0,    0,    0);     // fill byte
    push_cmd(CMD_READ_BYTE,    3, 1023, 0,    0);
    push_cmd(CMD_WRITE_BYTE,   0, 0,    0,    8'h00);
    push_cmd(CMD_WRITE_BYTE,   1, 1023, 2047, 8'hFF);
    push_cmd(CMD_COMMIT_WRITE, 0, 0,    0,    0);
    push_cmd(CMD_COMMIT_WRITE, 2, 0,    1,    0);
    push_cmd(CMD_READ_BYTE,    0, 0,    2047, 0);     // tail behind head
    push_cmd(CMD_COMMIT_READ,  0, 0,    1,    0);     // tail meets head
    push_cmd(CMD_COMMIT_WRITE, 0, 0,    1024, 0);     // full lap
    push_cmd(CMD_COMMIT_WRITE, 0, 0,    1025, 0);     // too long
    push_cmd(CMD_COMMIT_READ,  1, 0,    2047, 0);     // too long
    push_cmd(CMD_COMMIT_READ,  3, 0,    1023, 0);     // tail past head, wrap cut
    push_cmd(CMD_READ_BYTE,    3, 1,    0,    0);
    wait_idle();

    // Directed, smallest ring (a written 0 is taken as 2), all readers
    write_reg(CFG_RING_LENGTH, 0);
    write_reg(CFG_ACTIVE_READERS, 4);
    push_cmd(CMD_WRITE_BYTE,   0, 2,    0,    8'h11); // offset out of range
    push_cmd(CMD_WRITE_BYTE,   0, 1023, 0,    8'h22);
    push_cmd(CMD_READ_BYTE,    2, 2,    0,    0);
    push_cmd(CMD_WRITE_BYTE,   0, 1,    0,    8'hA5);
    push_cmd(CMD_COMMIT_WRITE, 0, 0,    2,    0);     // wraps to zero
    push_cmd(CMD_COMMIT_WRITE, 0, 0,    3,    0);     // too long
    push_cmd(CMD_COMMIT_WRITE, 1, 0,    1,    0);
    push_cmd(CMD_READ_BYTE,    0, 1,    2,    0);
    push_cmd(CMD_COMMIT_READ,  2, 0,    2,    0);
    push_cmd(CMD_COMMIT_READ,  2, 0,    3,    0);     // too long

    run_phase(2,    4, PACE_NONE, 100, 1'b0, 1'b0);
    run_phase(2047, 0, PACE_SEND, 150, 1'b0, 1'b0);
    run_phase(5,    7, PACE_RECV, 150, 1'b0, 1'b0);
    run_phase(1,    2, PACE_BOTH, 150, 1'b0, 1'b0);
    run_phase(100,  3, PACE_NONE, 200, 1'b1, 1'b0);
    run_phase(1023, 4, PACE_BOTH, 250, 1'b0, 1'b0);
    run_phase(17,   1, PACE_NONE, 200, 1'b0, 1'b1);

    wait_idle();
    $display("Covered %0d commands: %0d byte writes, %0d write commits,",
             sent, cmd_count[0], cmd_count[1]);
    $display("  %0d byte reads, %0d read commits", cmd_count[2], cmd_count[3]);
    $display("Ring lengths 2 to 1024 with 0 to 4 readers, under gaps, stalls and a full back-up");
    if (error_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[multi_reader_ring_buffer.f]
design/mrrb_pkg.sv
design/mrrb_ram.sv
design/mrrb_fifo.sv
design/mrrb_front.sv
design/mrrb_back.sv
design/multi_reader_ring_buffer.sv
dv/ring_result_checker.sv
dv/tb_multi_reader_ring_buffer.sv
